### hw/rtl/isfe_pkg.sv
package isfe_pkg;

	// Fixed field widths of the input and result words.
	localparam int KIND_W  = 2;
	localparam int COORD_W = 6;
	localparam int E_W     = 18;
	localparam int M_W     = 14;
	localparam int J_W     = 5;
	localparam int NSUM_W  = 4;
	localparam int STEP_W  = 3;

	// Saturation limits of the result fields.
	localparam int E_MAX = 131071;
	localparam int E_MIN = -131072;
	localparam int M_MAX = 8191;
	localparam int M_MIN = -8192;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE   = 2'd0,
		KIND_PROPOSE = 2'd1,
		KIND_FLIP    = 2'd2,
		KIND_MEASURE = 2'd3
	} kind_t;

	// Read steps of a propose item: the site, then its four neighbours.
	localparam logic [STEP_W-1:0] STEP_SITE  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_UP    = 3'd1;
	localparam logic [STEP_W-1:0] STEP_DOWN  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_LEFT  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_RIGHT = 3'd4;

	// Read steps of a measure sweep: the site, its right and its lower neighbour.
	localparam logic [STEP_W-1:0] STEP_EAST  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_SOUTH = 3'd2;

endpackage

### hw/rtl/isfe_chan_if.sv
interface isfe_in_if import isfe_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic [COORD_W-1:0]        row;
	logic [COORD_W-1:0]        col;
	logic                      spin_up;
	logic signed [E_W-1:0]     energy_now;
	logic signed [M_W-1:0]     magnet_now;

	modport source (output valid, kind, row, col, spin_up, energy_now, magnet_now,
		input ready);
	modport sink (input valid, kind, row, col, spin_up, energy_now, magnet_now,
		output ready);
endinterface

interface isfe_out_if import isfe_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [E_W-1:0]     energy_out;
	logic signed [M_W-1:0]     magnet_out;
	logic                      is_total;

	modport source (output valid, energy_out, magnet_out, is_total, input ready);
	modport sink (input valid, energy_out, magnet_out, is_total, output ready);
endinterface

### hw/rtl/ising_lattice_spin_flip_engine_top.sv
// Channel   Direction  Handshake      Word
// in_ch     in         valid/ready    kind, row, col, spin_up, energy_now, magnet_now
// out_ch    out        valid/ready    energy_out, magnet_out, is_total
// cfg       in         cfg_we         cfg_wdata (coupling J)
//
// A write word goes straight into memory; a flip word inverts the site recorded
// by the last propose word; propose and measure words end in the output register.
// The sequencing follows from the single port of the spin memory, which gives
// one site per cycle, and from the one multiplier shared by propose and measure.
// Reset clears the sequencer, the recorded site and sets the coupling to one; the
// spin memory is not cleared. The input side is taken again while a result waits
// in the output register; only a second result waits for the first to be taken.
module ising_lattice_spin_flip_engine_top import isfe_pkg::*; #(
	parameter int SIDE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	isfe_in_if.sink               in_ch,
	isfe_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic signed [J_W-1:0] cfg_wdata
);

	// A site is addressed as {row, column}, each of IDX_W bits, so the memory holds
	// a power of two rows of a power of two columns of which SIDE by SIDE are used.
	localparam int IDX_W  = (SIDE > 1) ? $clog2(SIDE) : 1;
	localparam int ADDR_W = 2 * IDX_W;
	// The magnetization lies within plus or minus SIDE*SIDE, the bond sum within
	// plus or minus twice that.
	localparam int MAG_W  = $clog2(SIDE * SIDE + 1) + 1;
	localparam int BOND_W = $clog2(2 * SIDE * SIDE + 1) + 1;
	localparam int PROD_W = BOND_W + J_W;
	localparam int ES_W   = ((PROD_W > E_W) ? PROD_W : E_W) + 2;
	localparam int MS_W   = ((MAG_W > M_W) ? MAG_W : M_W) + 2;

	localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(SIDE - 1);
	localparam logic signed [ES_W-1:0] E_HI    = ES_W'(E_MAX);
	localparam logic signed [ES_W-1:0] E_LO    = ES_W'(E_MIN);
	localparam logic signed [MS_W-1:0] M_HI    = MS_W'(M_MAX);
	localparam logic signed [MS_W-1:0] M_LO    = MS_W'(M_MIN);
	localparam logic signed [MS_W-1:0] M_TWO   = MS_W'(2);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_FLIP_RD = 9'b000000010,
		S_FLIP_WR = 9'b000000100,
		S_PROP_RD = 9'b000001000,
		S_MEAS_RD = 9'b000010000,
		S_DRAIN   = 9'b000100000,
		S_MUL     = 9'b001000000,
		S_SUM     = 9'b010000000,
		S_FIN     = 9'b100000000
	} state_t;

	state_t                     state_q;
	logic [STEP_W-1:0]          step_q;
	logic [IDX_W-1:0]           row_q, col_q;
	logic [IDX_W-1:0]           pend_row_q, pend_col_q;
	logic [IDX_W-1:0]           i_q, j_q;
	logic                       is_meas_q;
	logic signed [E_W-1:0]      e_in_q;
	logic signed [M_W-1:0]      m_in_q;
	logic signed [J_W-1:0]      coupling_q;
	logic                       s_q;
	logic                       cur_s_q;
	logic signed [NSUM_W-1:0]   nsum_q;
	logic signed [BOND_W-1:0]   bonds_q;
	logic signed [MAG_W-1:0]    mag_q;
	logic                       rd_vld_q;
	logic [STEP_W-1:0]          rd_step_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [E_W-1:0]      res_e_q;
	logic signed [M_W-1:0]      res_m_q;
	logic                       out_valid_q;
	logic signed [E_W-1:0]      out_e_q;
	logic signed [M_W-1:0]      out_m_q;
	logic                       out_total_q;

	logic                       accept;
	kind_t                      in_kind;
	logic [IDX_W-1:0]           in_row, in_col;
	logic [IDX_W-1:0]           ram_row, ram_col;
	logic                       ram_we, ram_wbit, ram_re, ram_rbit;
	logic signed [BOND_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [ES_W-1:0]     prod_x, two_p, e_x, e_wide;
	logic signed [MS_W-1:0]     m_x, m_wide;
	logic                       out_load;

	// Row and column numbers beyond the lattice fold back modulo SIDE through a
	// small constant table over every value the six-bit field can carry.
	logic [IDX_W-1:0] mod_tab [2**COORD_W];
	for (genvar g = 0; g < 2**COORD_W; g++) begin : g_mod
		assign mod_tab[g] = IDX_W'(g % SIDE);
	end

	function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] x);
		return (x == IDX_LAST) ? '0 : x + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] dec_wrap(input logic [IDX_W-1:0] x);
		return (x == '0) ? IDX_LAST : x - IDX_W'(1);
	endfunction

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_kind     = kind_t'(in_ch.kind);
	assign in_row      = mod_tab[in_ch.row];
	assign in_col      = mod_tab[in_ch.col];

	// Memory address and strobes. A write word goes straight into the memory in
	// the cycle it is accepted; every other access is issued by the sequencer.
	always_comb begin
		ram_row  = row_q;
		ram_col  = col_q;
		ram_we   = 1'b0;
		ram_wbit = 1'b0;
		ram_re   = 1'b0;
		case (state_q)
			S_IDLE: begin
				ram_row  = in_row;
				ram_col  = in_col;
				ram_we   = accept && (in_kind == KIND_WRITE);
				ram_wbit = in_ch.spin_up;
			end
			S_FLIP_RD: begin
				ram_row = pend_row_q;
				ram_col = pend_col_q;
				ram_re  = 1'b1;
			end
			S_FLIP_WR: begin
				ram_row  = pend_row_q;
				ram_col  = pend_col_q;
				ram_we   = 1'b1;
				ram_wbit = ~ram_rbit;
			end
			S_PROP_RD: begin
				ram_re = 1'b1;
				case (step_q)
					STEP_UP:    ram_row = dec_wrap(row_q);
					STEP_DOWN:  ram_row = inc_wrap(row_q);
					STEP_LEFT:  ram_col = dec_wrap(col_q);
					STEP_RIGHT: ram_col = inc_wrap(col_q);
					default: begin
						ram_row = row_q;
						ram_col = col_q;
					end
				endcase
			end
			S_MEAS_RD: begin
				ram_re  = 1'b1;
				ram_row = i_q;
				ram_col = j_q;
				case (step_q)
					STEP_EAST:  ram_col = inc_wrap(j_q);
					STEP_SOUTH: ram_row = inc_wrap(i_q);
					default: begin
						ram_row = i_q;
						ram_col = j_q;
					end
				endcase
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	isfe_spin_ram #(
		.ADDR_W (ADDR_W)
	) u_spin_ram (
		.clk  (clk),
		.addr ({ram_row, ram_col}),
		.we   (ram_we),
		.wbit (ram_wbit),
		.re   (ram_re),
		.rbit (ram_rbit)
	);

	// The one multiplier serves both J times the neighbour sum of a propose and
	// J times the bond sum of a measure.
	always_comb begin
		mul_b = is_meas_q ? bonds_q : BOND_W'(nsum_q);
		mul_p = coupling_q * mul_b;
	end

	// Final add and saturation. A propose adds 2*J*s*nsum to the supplied energy
	// and takes 2*s off the supplied magnetization; a measure negates J times
	// the bond sum, as every bond is counted once, from the site at its left or upper end.
	always_comb begin
		prod_x = ES_W'(prod_q);
		two_p  = prod_x <<< 1;
		e_x    = ES_W'(e_in_q);
		m_x    = MS_W'(m_in_q);
		if (is_meas_q) begin
			e_wide = -prod_x;
			m_wide = MS_W'(mag_q);
		end else if (s_q) begin
			e_wide = e_x + two_p;
			m_wide = m_x - M_TWO;
		end else begin
			e_wide = e_x - two_p;
			m_wide = m_x + M_TWO;
		end
	end

	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			pend_row_q  <= '0;
			pend_col_q  <= '0;
			is_meas_q   <= 1'b0;
			coupling_q  <= J_W'(1);
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				coupling_q <= cfg_wdata;
			end
			rd_vld_q <= ram_re;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= '0;
						case (in_kind)
							KIND_FLIP: begin
								state_q <= S_FLIP_RD;
							end
							KIND_PROPOSE: begin
								is_meas_q  <= 1'b0;
								pend_row_q <= in_row;
								pend_col_q <= in_col;
								state_q    <= S_PROP_RD;
							end
							KIND_MEASURE: begin
								is_meas_q <= 1'b1;
								state_q   <= S_MEAS_RD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_FLIP_RD: begin
					state_q <= S_FLIP_WR;
				end
				S_FLIP_WR: begin
					state_q <= S_IDLE;
				end
				S_PROP_RD: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_RIGHT) begin
						state_q <= S_DRAIN;
					end
				end
				S_MEAS_RD: begin
					if (step_q == STEP_SOUTH) begin
						step_q <= '0;
						if (j_q == IDX_LAST) begin
							if (i_q == IDX_LAST) begin
								state_q <= S_DRAIN;
							end
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: site, sweep position, accumulators and results.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q   <= in_row;
			col_q   <= in_col;
			e_in_q  <= in_ch.energy_now;
			m_in_q  <= in_ch.magnet_now;
			i_q     <= '0;
			j_q     <= '0;
			nsum_q  <= '0;
			bonds_q <= '0;
			mag_q   <= '0;
		end

		if ((state_q == S_MEAS_RD) && (step_q == STEP_SOUTH)) begin
			if (j_q == IDX_LAST) begin
				j_q <= '0;
				i_q <= inc_wrap(i_q);
			end else begin
				j_q <= j_q + IDX_W'(1);
			end
		end

		// Returned memory bits: one per cycle, tagged with the step that asked.
		if (rd_vld_q && (state_q != S_FLIP_WR)) begin
			if (is_meas_q) begin
				if (rd_step_q == STEP_SITE) begin
					cur_s_q <= ram_rbit;
					mag_q   <= ram_rbit ? mag_q + MAG_W'(1) : mag_q - MAG_W'(1);
				end else begin
					bonds_q <= (cur_s_q == ram_rbit) ? bonds_q + BOND_W'(1)
						: bonds_q - BOND_W'(1);
				end
			end else begin
				if (rd_step_q == STEP_SITE) begin
					s_q <= ram_rbit;
				end else begin
					nsum_q <= ram_rbit ? nsum_q + NSUM_W'(1) : nsum_q - NSUM_W'(1);
				end
			end
		end
		rd_step_q <= step_q;

		if (state_q == S_MUL) begin
			prod_q <= mul_p;
		end

		if (state_q == S_SUM) begin
			if (e_wide > E_HI) begin
				res_e_q <= E_W'(E_HI);
			end else if (e_wide < E_LO) begin
				res_e_q <= E_W'(E_LO);
			end else begin
				res_e_q <= E_W'(e_wide);
			end
			if (m_wide > M_HI) begin
				res_m_q <= M_W'(M_HI);
			end else if (m_wide < M_LO) begin
				res_m_q <= M_W'(M_LO);
			end else begin
				res_m_q <= M_W'(m_wide);
			end
		end

		if (out_load) begin
			out_e_q     <= res_e_q;
			out_m_q     <= res_m_q;
			out_total_q <= is_meas_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.energy_out = out_e_q;
	assign out_ch.magnet_out = out_m_q;
	assign out_ch.is_total   = out_total_q;

endmodule

### hw/rtl/isfe_spin_ram.sv
module isfe_spin_ram #(
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic [ADDR_W-1:0] addr,
	input  logic              we,
	input  logic              wbit,
	input  logic              re,
	output logic              rbit
);

	// One bit per site, a single port shared by reads and writes.
	logic mem_q [2**ADDR_W];
	logic rbit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wbit;
		end
		if (re) begin
			rbit_q <= mem_q[addr];
		end
	end

	assign rbit = rbit_q;

endmodule
